>>> rtl/core/gtcw_pkg.sv
// ============================================================================
// gtcw_pkg
// Shared types, constants and the 5x7 font table for the text column writer.
// ============================================================================
`default_nettype none

package gtcw_pkg;

    // Layout of the text area.
    localparam int CHARS_PER_LINE = 16;
    localparam int PAGE_COUNT     = 8;
    localparam int GLYPH_ENTRIES  = 96;

    localparam int SLOT_W   = (CHARS_PER_LINE > 1) ? $clog2(CHARS_PER_LINE) : 1;
    localparam int PAGE_W   = 3;
    localparam int GLYPH_W  = 7;
    localparam int COLS     = 5;
    localparam int ROW_W    = 8 * COLS;
    localparam int FONT_ROWS = 96;

    // Display controller command codes.
    localparam logic [7:0] CMD_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_COLUMN = 8'h40;
    localparam logic [7:0] FIRST_GLYPH_CODE = 8'd32;
    localparam logic [7:0] LAST_GLYPH_CODE  = 8'd127;
    localparam logic [7:0] FIRST_LINE_CODE  = 8'd1;
    localparam logic [7:0] LAST_LINE_CODE   = 8'd8;

    // Write sequence steps in the back end.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_POS_LAST   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_GLYPH_LAST = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CHAR_LAST  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_WRAP_FIRST = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WRAP_LAST  = 4'd11;

    // Queue between front and back.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    // One classified character, as handed from front to back.
    typedef struct packed {
        logic              line_sel;  // positioning only
        logic              wrap;      // glyph followed by positioning
        logic              right;     // controller for glyph columns
        logic [PAGE_W-1:0] page;      // page for positioning commands
        logic [ROW_W-1:0]  row;       // glyph columns, column 0 in the top byte
    } gtcw_cmd_t;

    localparam logic [ROW_W-1:0] FONT [FONT_ROWS] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0030300000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0008142241, 40'h1414141414,
        40'h4122140800, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
        40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
        40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h007F102844, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000,
        40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

endpackage

`default_nettype wire

>>> rtl/core/gtcw_front.sv
// ============================================================================
// gtcw_front
// Classifies each character, keeps the cursor and queues one command per beat.
// ============================================================================
`default_nettype none

module gtcw_front
    import gtcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_code,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic       q_full,
    output logic            q_push,
    output gtcw_cmd_t       q_cmd
);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [PAGE_W-1:0] page_reg, page_next;

    logic              is_line;
    logic              is_glyph;
    logic [GLYPH_W-1:0] glyph_idx;
    logic [SLOT_W:0]   slot_inc;
    logic [PAGE_W:0]   page_inc;
    logic [PAGE_W-1:0] sel_page;
    logic              wrap;
    logic [PAGE_W-1:0] wrap_page;

    // Reduces code-1 (0..7) modulo the page count by repeated subtraction.
    function automatic logic [PAGE_W-1:0] page_mod(input logic [PAGE_W-1:0] v);
        logic [PAGE_W:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= (PAGE_W+1)'(PAGE_COUNT))
            begin
                r = r - (PAGE_W+1)'(PAGE_COUNT);
            end
        end
        return r[PAGE_W-1:0];
    endfunction

    assign char_ready = !q_full;
    assign q_push     = char_valid && char_ready;

    always_comb
    begin
        is_line  = (char_code >= FIRST_LINE_CODE) && (char_code <= LAST_LINE_CODE);
        is_glyph = (char_code >= FIRST_GLYPH_CODE) && (char_code <= LAST_GLYPH_CODE)
                   && ((char_code - FIRST_GLYPH_CODE) < 8'(GLYPH_ENTRIES));
        glyph_idx = is_glyph ? GLYPH_W'(char_code - FIRST_GLYPH_CODE) : '0;
        sel_page  = page_mod(PAGE_W'(char_code - FIRST_LINE_CODE));

        slot_inc  = {1'b0, slot_reg} + 1'b1;
        wrap      = slot_inc >= (SLOT_W+1)'(CHARS_PER_LINE);
        page_inc  = {1'b0, page_reg} + 1'b1;
        wrap_page = (page_inc >= (PAGE_W+1)'(PAGE_COUNT)) ? '0 : page_inc[PAGE_W-1:0];

        q_cmd.line_sel = is_line;
        q_cmd.wrap     = !is_line && wrap;
        q_cmd.right    = slot_reg >= SLOT_W'(CHARS_PER_LINE / 2);
        q_cmd.page     = is_line ? sel_page : wrap_page;
        q_cmd.row      = FONT[glyph_idx];

        slot_next = slot_reg;
        page_next = page_reg;
        if (q_push)
        begin
            if (is_line)
            begin
                slot_next = '0;
                page_next = sel_page;
            end
            else if (wrap)
            begin
                slot_next = '0;
                page_next = wrap_page;
            end
            else
            begin
                slot_next = slot_inc[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            page_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            page_reg <= page_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gtcw_cmd_fifo.sv
// ============================================================================
// gtcw_cmd_fifo
// Short command queue that decouples the front end from the write sequencer.
// ============================================================================
`default_nettype none

module gtcw_cmd_fifo
    import gtcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire gtcw_cmd_t push_cmd,
    input  wire logic      pop,
    output logic           full,
    output logic           empty,
    output gtcw_cmd_t      head
);

    gtcw_cmd_t             slots_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0]  count_reg, count_next;

    function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
        return (p == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gtcw_back.sv
// ============================================================================
// gtcw_back
// Write sequencer: expands the queued command into display writes, one a cycle unless write_ready stalls.
// ============================================================================
`default_nettype none

module gtcw_back
    import gtcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_empty,
    input  wire gtcw_cmd_t q_head,
    output logic           q_pop,
    output logic [7:0]     write_byte,
    output logic           is_data,
    output logic           right_half,
    output logic           last_write,
    output logic           write_valid,
    input  wire logic      write_ready
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              data_reg, data_next;
    logic              right_reg, right_next;
    logic              last_reg, last_next;

    logic              advance;
    logic [STEP_W-1:0] pos_step;

    assign advance = !valid_reg || write_ready;

    always_comb
    begin
        // Step within the four positioning commands.
        pos_step = q_head.line_sel ? step_reg : step_reg - STEP_WRAP_FIRST;

        if (q_head.line_sel || step_reg >= STEP_WRAP_FIRST)
        begin
            data_next  = 1'b0;
            right_next = pos_step[0];
            byte_next  = pos_step[1] ? CMD_COLUMN : (CMD_PAGE | {5'd0, q_head.page});
        end
        else
        begin
            data_next  = 1'b1;
            right_next = q_head.right;
            case (step_reg)
                4'd0:    byte_next = q_head.row[39:32];
                4'd1:    byte_next = q_head.row[31:24];
                4'd2:    byte_next = q_head.row[23:16];
                4'd3:    byte_next = q_head.row[15:8];
                4'd4:    byte_next = q_head.row[7:0];
                default: byte_next = 8'd0;
            endcase
        end

        if (q_head.line_sel)
        begin
            last_next = step_reg == STEP_POS_LAST;
        end
        else if (q_head.wrap)
        begin
            last_next = step_reg == STEP_WRAP_LAST;
        end
        else
        begin
            last_next = step_reg == STEP_CHAR_LAST;
        end

        q_pop      = !q_empty && advance && last_next;
        valid_next = advance ? !q_empty : valid_reg;
        step_next  = step_reg;
        if (!q_empty && advance)
        begin
            step_next = last_next ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg  <= byte_next;
            data_reg  <= data_next;
            right_reg <= right_next;
            last_reg  <= last_next;
        end
    end

    assign write_valid = valid_reg;
    assign write_byte  = byte_reg;
    assign is_data     = data_reg;
    assign right_half  = right_reg;
    assign last_write  = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/glcd_text_column_writer_core.sv
// ============================================================================
// glcd_text_column_writer_core
// Text renderer for a two-controller 128x64 LCD with a 5x7 font.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------------
//  char      char_valid / char_ready    char_code[7:0]
//  write     write_valid / write_ready  write_byte[7:0], is_data, right_half,
//                                       last_write
//
//  The output side emits one write beat per cycle unless stalled by write_ready
//  or an empty queue: 8 beats for a character, 12 when it ends a line, 4 for
//  a line select, from the single write sequencer. Characters are taken into a
//  two-entry command queue while earlier ones are still being written out;
//  char_ready drops only while that queue is full. Reset puts the cursor at
//  slot 0 of page 0 and empties the queue and output register.
//
`default_nettype none

module glcd_text_column_writer_core
    import gtcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_code,
    input  wire logic       char_valid,
    output logic            char_ready,
    output logic [7:0]      write_byte,
    output logic            is_data,
    output logic            right_half,
    output logic            last_write,
    output logic            write_valid,
    input  wire logic       write_ready
);

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    gtcw_cmd_t q_cmd;
    gtcw_cmd_t q_head;

    gtcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    gtcw_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    gtcw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .write_byte  (write_byte),
        .is_data     (is_data),
        .right_half  (right_half),
        .last_write  (last_write),
        .write_valid (write_valid),
        .write_ready (write_ready)
    );

endmodule

`default_nettype wire

>>> rtl/core/gtcw_checker.sv
// ============================================================================
// gtcw_checker
// Port-level checks on the write stream of the text column writer.
// ============================================================================
`default_nettype none

module gtcw_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic [7:0] char_code,
    input wire logic       char_valid,
    input wire logic       char_ready,
    input wire logic [7:0] write_byte,
    input wire logic       is_data,
    input wire logic       right_half,
    input wire logic       last_write,
    input wire logic       write_valid,
    input wire logic       write_ready
);

    // A waiting character beat keeps its code.
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_code))
        else $error("character beat changed while waiting");

    // A stalled write beat keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && !write_ready |=> write_valid && $stable(write_byte)
            && $stable(is_data) && $stable(right_half) && $stable(last_write))
        else $error("write beat changed while stalled");

    // Commands are only page selects or the column-zero command.
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && !is_data |-> (write_byte[7:3] == 5'b10111 || write_byte == 8'h40))
        else $error("unexpected command byte");

    // Font columns use seven pixel rows only.
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && is_data |-> !write_byte[7])
        else $error("data byte uses the eighth row");

    // Positioning always finishes on the right controller.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && last_write && !is_data |-> right_half && write_byte == 8'h40)
        else $error("positioning ended on the wrong command");

endmodule

bind glcd_text_column_writer_core gtcw_checker u_gtcw_checker (.*);

`default_nettype wire
